@@ rtl/hsd_pkg.sv @@
package hsd_pkg;

    localparam int MAX_CODE_BITS = 71;
    localparam int DATA_BITS     = 64;
    localparam int BUF_BITS      = DATA_BITS + 7;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    localparam logic [2:0] MODE_D8  = 3'd0;
    localparam logic [2:0] MODE_D12 = 3'd1;
    localparam logic [2:0] MODE_D16 = 3'd2;
    localparam logic [2:0] MODE_D32 = 3'd3;
    localparam logic [2:0] MODE_D64 = 3'd4;

    localparam int LEN_D8  = 12;
    localparam int LEN_D12 = 17;
    localparam int LEN_D16 = 21;
    localparam int LEN_D32 = 38;
    localparam int LEN_D64 = 71;

    typedef struct packed {
        logic [MAX_CODE_BITS-1:0] word;
        logic [2:0]               mode;
    } t_word_beat;

    function automatic logic [6:0] code_len(input logic [2:0] m);
        logic [6:0] l;
        unique case (m)
            MODE_D8:  l = 7'(LEN_D8);
            MODE_D12: l = 7'(LEN_D12);
            MODE_D16: l = 7'(LEN_D16);
            MODE_D32: l = 7'(LEN_D32);
            MODE_D64: l = 7'(LEN_D64);
            default:  l = 7'd0;
        endcase
        return l;
    endfunction

    function automatic logic [2:0] bits_per_byte(input logic [2:0] m);
        logic [2:0] k;
        unique case (m)
            MODE_D8:  k = 3'd6;
            MODE_D12: k = 3'd1;
            MODE_D16: k = 3'd7;
            MODE_D32: k = 3'd2;
            MODE_D64: k = 3'd1;
            default:  k = 3'd0;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] data_count(input logic [2:0] m);
        logic [6:0] c;
        unique case (m)
            MODE_D8:  c = 7'd8;
            MODE_D12: c = 7'd12;
            MODE_D16: c = 7'd16;
            MODE_D32: c = 7'd32;
            MODE_D64: c = 7'd64;
            default:  c = 7'd0;
        endcase
        return c;
    endfunction

    function automatic logic mode_ok(input logic [2:0] m);
        return (m <= MODE_D64) && (code_len(m) != 7'd0)
            && (32'(code_len(m)) <= 32'(MAX_CODE_BITS));
    endfunction

    // position j of the codeword lands at bit j-1
    function automatic logic [MAX_CODE_BITS-1:0] reorder(
        input logic [MAX_CODE_BITS-1:0] w,
        input int                       len
    );
        logic [MAX_CODE_BITS-1:0] o;
        o = '0;
        for (int i = 0; i < MAX_CODE_BITS; i++) begin
            if (i < len) begin
                o[i] = w[7'(len - 1 - i)];
            end
        end
        return o;
    endfunction

    function automatic logic [DATA_BITS-1:0] fix_and_extract(
        input logic [MAX_CODE_BITS-1:0] w,
        input int                       len
    );
        logic [MAX_CODE_BITS-1:0] c;
        logic [DATA_BITS-1:0]     d;
        logic [6:0]               syn;
        logic                     par;
        int                       cnt;
        c   = w;
        d   = '0;
        syn = '0;
        cnt = 0;
        for (int p = 0; p < 7; p++) begin
            par = 1'b0;
            for (int j = 1; j <= MAX_CODE_BITS; j++) begin
                if (j <= len && (j & (1 << p)) != 0) begin
                    par = par ^ w[j-1];
                end
            end
            if ((1 << p) <= len) begin
                syn[p] = par;
            end
        end
        if (syn != 7'd0 && 32'(syn) <= 32'(len)) begin
            c[7'(syn - 7'd1)] = ~c[7'(syn - 7'd1)];
        end
        for (int j = 1; j <= MAX_CODE_BITS; j++) begin
            if (j <= len && (j & (j - 1)) != 0 && cnt < DATA_BITS) begin
                d[6'(DATA_BITS - 1 - cnt)] = c[j-1];
                cnt++;
            end
        end
        return d;
    endfunction

    function automatic logic [DATA_BITS-1:0] decode_word(
        input logic [MAX_CODE_BITS-1:0] w,
        input logic [2:0]               m
    );
        logic [DATA_BITS-1:0] d;
        unique case (m)
            MODE_D8:  d = fix_and_extract(w, LEN_D8);
            MODE_D12: d = fix_and_extract(w, LEN_D12);
            MODE_D16: d = fix_and_extract(w, LEN_D16);
            MODE_D32: d = fix_and_extract(w, LEN_D32);
            MODE_D64: d = fix_and_extract(w, LEN_D64);
            default:  d = '0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/hsd_front.sv @@
module hsd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clr,
    input  logic [2:0]             i_mode,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_in_byte,
    output logic                   o_push_valid,
    input  logic                   i_push_ready,
    output hsd_pkg::t_word_beat    o_push
);

    logic [hsd_pkg::MAX_CODE_BITS-1:0] r_word, n_word, w_norm;
    logic [6:0]                        r_fill, n_fill, w_fill_inc;
    logic                              w_acc, w_ok, w_done;

    assign o_ready    = i_push_ready;
    assign w_acc      = i_valid && i_push_ready;
    assign w_ok       = hsd_pkg::mode_ok(i_mode);
    assign w_fill_inc = 7'(r_fill + 7'(hsd_pkg::bits_per_byte(i_mode)));
    assign w_done     = (w_fill_inc == hsd_pkg::code_len(i_mode));

    always_comb begin
        unique case (i_mode)
            hsd_pkg::MODE_D8: begin
                n_word = {r_word[hsd_pkg::MAX_CODE_BITS-7:0], i_in_byte[5:0]};
                w_norm = hsd_pkg::reorder(n_word, hsd_pkg::LEN_D8);
            end
            hsd_pkg::MODE_D12: begin
                n_word = {r_word[hsd_pkg::MAX_CODE_BITS-2:0], i_in_byte[0]};
                w_norm = hsd_pkg::reorder(n_word, hsd_pkg::LEN_D12);
            end
            hsd_pkg::MODE_D16: begin
                n_word = {r_word[hsd_pkg::MAX_CODE_BITS-8:0], i_in_byte[6:0]};
                w_norm = hsd_pkg::reorder(n_word, hsd_pkg::LEN_D16);
            end
            hsd_pkg::MODE_D32: begin
                n_word = {r_word[hsd_pkg::MAX_CODE_BITS-3:0], i_in_byte[1:0]};
                w_norm = hsd_pkg::reorder(n_word, hsd_pkg::LEN_D32);
            end
            hsd_pkg::MODE_D64: begin
                n_word = {r_word[hsd_pkg::MAX_CODE_BITS-2:0], i_in_byte[0]};
                w_norm = hsd_pkg::reorder(n_word, hsd_pkg::LEN_D64);
            end
            default: begin
                n_word = r_word;
                w_norm = '0;
            end
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        if (i_clr) begin
            n_fill = 7'd0;
        end else if (w_acc && w_ok) begin
            n_fill = w_done ? 7'd0 : w_fill_inc;
        end
    end

    assign o_push_valid = w_acc && w_ok && w_done && !i_clr;
    assign o_push.word  = w_norm;
    assign o_push.mode  = i_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 7'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_ok) begin
            r_word <= n_word;
        end
    end

endmodule

@@ rtl/hsd_fifo.sv @@
module hsd_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clr,
    input  logic                   i_push_valid,
    output logic                   o_push_ready,
    input  hsd_pkg::t_word_beat    i_push,
    output logic                   o_pop_valid,
    input  logic                   i_pop_ready,
    output hsd_pkg::t_word_beat    o_pop
);

    hsd_pkg::t_word_beat          r_mem [hsd_pkg::FIFO_DEPTH];
    logic [hsd_pkg::FIFO_AW-1:0]  r_wp, r_rp;
    logic [hsd_pkg::FIFO_AW:0]    r_cnt;
    logic                         w_push, w_pop;

    assign o_push_ready = (r_cnt != (hsd_pkg::FIFO_AW + 1)'(hsd_pkg::FIFO_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop        = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (hsd_pkg::FIFO_AW + 1)'(w_push)
                           - (hsd_pkg::FIFO_AW + 1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push;
        end
    end

endmodule

@@ rtl/hsd_back.sv @@
module hsd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clr,
    input  logic                   i_word_valid,
    output logic                   o_word_ready,
    input  hsd_pkg::t_word_beat    i_word,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_data_byte,
    output logic                   o_last_of_run
);

    logic [hsd_pkg::DATA_BITS-1:0] r_data;
    logic [6:0]                    r_dcnt;
    logic                          r_dvalid;
    logic [hsd_pkg::BUF_BITS-1:0]  r_buf, n_buf, w_buf_a;
    logic [6:0]                    r_cnt, n_cnt, w_cnt_a;
    logic                          w_fire, w_load, w_pop;

    assign o_valid       = (r_cnt >= 7'd8);
    assign o_data_byte   = r_buf[hsd_pkg::BUF_BITS-1 -: 8];
    assign o_last_of_run = (r_cnt < 7'd16);
    assign w_fire        = o_valid && i_ready;

    always_comb begin
        w_cnt_a = w_fire ? 7'(r_cnt - 7'd8) : r_cnt;
        w_buf_a = w_fire ? (r_buf << 8) : r_buf;
        w_load  = r_dvalid && (w_cnt_a < 7'd8);
        n_cnt   = w_cnt_a;
        n_buf   = w_buf_a;
        if (w_load) begin
            n_buf = w_buf_a | ({r_data, 7'b0} >> w_cnt_a[2:0]);
            n_cnt = 7'(w_cnt_a + r_dcnt);
        end
    end

    assign o_word_ready = !r_dvalid || w_load;
    assign w_pop        = i_word_valid && o_word_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_dvalid <= 1'b0;
            r_cnt    <= 7'd0;
            r_buf    <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_buf <= n_buf;
            if (w_pop) begin
                r_dvalid <= 1'b1;
            end else if (w_load) begin
                r_dvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_data <= hsd_pkg::decode_word(i_word.word, i_word.mode);
            r_dcnt <= hsd_pkg::data_count(i_word.mode);
        end
    end

endmodule

@@ rtl/hamming_sec_stream_decoder.sv @@
// Hamming single-error-correcting decoder on a byte stream.
// Input channel i_valid / o_ready / i_in_byte: one coded byte per beat; the
// low bits of each byte carry codeword bits, MSB first, as many as the mode
// takes. o_ready drops only while the two-entry word queue is full.
// Output channel o_valid / i_ready / o_data_byte / o_last_of_run: decoded
// data bytes, first data bit in the MSB; o_last_of_run marks the last full
// byte that the output buffer holds (fewer than 16 bits held).
// i_cfg_we / i_cfg_wdata write the decode mode and clear the partial
// codeword and carried data bits; write only while the block is idle.
// Throughput: one input beat per cycle while the queue is not full, one
// output beat per cycle while i_ready is high and decoded bits are held.
// A completed codeword passes the queue, the syndrome/correct register and
// the output buffer, then up to 8 bytes follow at one byte per cycle.
// When the receiver stalls, the output buffer holds its byte; the front
// keeps taking input until the queue fills, then o_ready drops.
// Reset: synchronous, active low; mode 0; counts, pointers and buffer cleared.
module hamming_sec_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_byte,
    output logic       o_last_of_run
);

    logic [2:0]          r_mode;
    logic                q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    hsd_pkg::t_word_beat q_push, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= hsd_pkg::MODE_D8;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    hsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (i_cfg_we),
        .i_mode       (r_mode),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .o_push_valid (q_push_valid),
        .i_push_ready (q_push_ready),
        .o_push       (q_push)
    );

    hsd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (i_cfg_we),
        .i_push_valid (q_push_valid),
        .o_push_ready (q_push_ready),
        .i_push       (q_push),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop        (q_pop)
    );

    hsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clr         (i_cfg_we),
        .i_word_valid  (q_pop_valid),
        .o_word_ready  (q_pop_ready),
        .i_word        (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data_byte   (o_data_byte),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTHESIS
    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push_valid |-> q_push_ready)
        else $error("word pushed into full queue");

    a_bad_mode_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode > hsd_pkg::MODE_D64) |-> !q_push_valid)
        else $error("word completed in unused mode");

    a_cfg_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_valid)
        else $error("output still valid after mode write");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && !i_cfg_we) |=>
            (o_valid && $stable(o_data_byte) && $stable(o_last_of_run)))
        else $error("output beat changed while stalled");
`endif

endmodule
